@@ src/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the stepper phase sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MICROSECOND_UNITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COIL_TABLE        = 2'd2;

    // Configuration data and field widths
    localparam int CFG_DATA_W = 32;
    localparam int DELAY_W    = 16;
    localparam int COUNT_W    = 16;
    localparam int PHASE_W    = 3;
    localparam int COIL_W     = 4;

    // Reset values of the configuration registers
    localparam logic [DELAY_W-1:0]    STEP_DELAY_RST = 16'd2;
    localparam logic [CFG_DATA_W-1:0] COIL_TABLE_RST = 32'd2563007025;

    // Input request codes
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    // One result word
    typedef struct packed {
        logic [COIL_W-1:0] coil_pattern;
        logic              busy_res;
        logic              step_taken;
        logic              command_rejected;
    } result_t;

endpackage

@@ src/sps_phase_step.sv @@
// ----------------------------------------------------------------------------
// sps_phase_step
// Next phase index for full-step or half-step motion and the coil lookup.
// ----------------------------------------------------------------------------
module sps_phase_step
    import sps_pkg::*;
(
    input  logic [PHASE_W-1:0]    phase,
    input  logic                  moving_back,
    input  logic                  half_mode,
    input  logic [CFG_DATA_W-1:0] coil_table,
    output logic [PHASE_W-1:0]    phase_next,
    output logic [COIL_W-1:0]     coil_next
);

    logic [PHASE_W:0] fwd_sum;

    // Full-step moves two from an odd index and one from an even index.
    assign fwd_sum = {1'b0, phase} + (phase[0] ? 4'd2 : 4'd1);

    always_comb
    begin
        if (half_mode)
        begin
            phase_next = moving_back ? (phase - 3'd1) : (phase + 3'd1);
        end
        else if (!moving_back)
        begin
            phase_next = (fwd_sum > 4'd7) ? 3'd1 : fwd_sum[PHASE_W-1:0];
        end
        else if (phase == 3'd0 || phase == 3'd1)
        begin
            phase_next = 3'd7;
        end
        else
        begin
            phase_next = phase - (phase[0] ? 3'd2 : 3'd1);
        end
    end

    // Pick the nibble of the coil table for the new index.
    assign coil_next = coil_table[{phase_next, 2'b00} +: COIL_W];

endmodule

@@ src/sps_out_buf.sv @@
// ----------------------------------------------------------------------------
// sps_out_buf
// Result register with a skid stage so the input side keeps flowing while a
// word waits on the output.
// ----------------------------------------------------------------------------
module sps_out_buf
    import sps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_word,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_word
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;
    logic    main_free;

    assign pop       = main_valid_reg && !out_stall;
    assign main_free = !main_valid_reg || pop;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

    // Valid flags for the main and skid stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload moves from skid to main when the main word is taken.
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_word;
        end
        else if (push)
        begin
            skid_reg <= push_word;
        end
    end

endmodule

@@ src/stepper_phase_sequencer.sv @@
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Throughput: one item per cycle while in_stall is low; the state update and
// coil lookup are combinational, and a two-word output buffer absorbs a
// single stalled result.
// Reset: asynchronous, coils off, phase 0, idle, configuration at defaults.
// Steps a unipolar stepper through an eight-entry coil table on move
// commands, pacing each step with a tick-driven delay counter.
// ----------------------------------------------------------------------------
module stepper_phase_sequencer
    import sps_pkg::*;
#(
    parameter int TICKS_PER_MS = 1000
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Item input
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic signed [COUNT_W-1:0] step_count,
    input  logic                  half_step,
    // Result output
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COIL_W-1:0]     coil_pattern,
    output logic                  busy_res,
    output logic                  step_taken,
    output logic                  command_rejected,
    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PRE_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
    localparam logic [PRE_W:0] TICKS_LIMIT = (PRE_W+1)'(TICKS_PER_MS);

    // Configuration registers
    logic [DELAY_W-1:0]    step_delay_reg;
    logic                  microsecond_units_reg;
    logic [CFG_DATA_W-1:0] coil_table_reg;

    // Sequencer state
    logic [PHASE_W-1:0] phase_index_reg,    phase_index_next;
    logic [COUNT_W-1:0] steps_left_reg,     steps_left_next;
    logic               moving_back_reg,    moving_back_next;
    logic               half_mode_reg,      half_mode_next;
    logic [DELAY_W-1:0] delay_left_reg,     delay_left_next;
    logic [PRE_W-1:0]   prescale_count_reg, prescale_count_next;
    logic               busy_flag_reg,      busy_flag_next;
    logic [COIL_W-1:0]  coil_out_reg,       coil_out_next;

    logic               in_accept;
    logic               buf_full;
    logic               take_step;
    logic               expire;
    logic               unit_done;
    logic               stepped;
    logic               rejected;
    logic [DELAY_W-1:0] delay_dec;
    logic [PRE_W:0]     prescale_inc;
    logic [PHASE_W-1:0] step_phase;
    logic [COIL_W-1:0]  step_coil;
    result_t            result;
    result_t            out_word;

    assign cfg_ready = 1'b1;
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !in_stall;

    // Configuration register writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_delay_reg        <= STEP_DELAY_RST;
            microsecond_units_reg <= 1'b0;
            coil_table_reg        <= COIL_TABLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP_DELAY:        step_delay_reg        <= cfg_data[DELAY_W-1:0];
                CFG_MICROSECOND_UNITS: microsecond_units_reg <= cfg_data[0];
                CFG_COIL_TABLE:        coil_table_reg        <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Phase advance and coil lookup for the step taken on this item.
    sps_phase_step u_phase_step (
        .phase       (phase_index_reg),
        .moving_back (moving_back_next),
        .half_mode   (half_mode_next),
        .coil_table  (coil_table_reg),
        .phase_next  (step_phase),
        .coil_next   (step_coil)
    );

    assign delay_dec    = delay_left_reg - 16'd1;
    assign prescale_inc = {1'b0, prescale_count_reg} + {{PRE_W{1'b0}}, 1'b1};

    // Command decode, delay countdown and step scheduling.
    always_comb
    begin
        moving_back_next    = moving_back_reg;
        half_mode_next      = half_mode_reg;
        steps_left_next     = steps_left_reg;
        busy_flag_next      = busy_flag_reg;
        delay_left_next     = delay_left_reg;
        prescale_count_next = prescale_count_reg;
        take_step           = 1'b0;
        expire              = 1'b0;
        unit_done           = 1'b0;
        rejected            = 1'b0;

        if (req_type == REQ_COMMAND)
        begin
            if (busy_flag_reg)
            begin
                rejected = 1'b1;
            end
            else if (step_count != '0)
            begin
                // Magnitude minus one: ~x for negative counts, x-1 otherwise.
                moving_back_next = step_count[COUNT_W-1];
                half_mode_next   = half_step;
                steps_left_next  = step_count[COUNT_W-1] ? ~step_count
                                                          : step_count - 16'sd1;
                busy_flag_next   = 1'b1;
                take_step        = 1'b1;
            end
        end
        else if (busy_flag_reg)
        begin
            if (delay_left_reg == '0)
            begin
                expire = 1'b1;
            end
            else
            begin
                if (microsecond_units_reg)
                begin
                    unit_done = 1'b1;
                end
                else if (prescale_inc >= TICKS_LIMIT)
                begin
                    prescale_count_next = '0;
                    unit_done           = 1'b1;
                end
                else
                begin
                    prescale_count_next = prescale_inc[PRE_W-1:0];
                end
                if (unit_done)
                begin
                    delay_left_next = delay_dec;
                    expire          = (delay_dec == '0);
                end
            end
            if (expire)
            begin
                if (steps_left_reg != '0)
                begin
                    steps_left_next = steps_left_reg - 16'd1;
                    take_step       = 1'b1;
                end
                else
                begin
                    busy_flag_next      = 1'b0;
                    prescale_count_next = '0;
                end
            end
        end

        phase_index_next = phase_index_reg;
        coil_out_next    = coil_out_reg;
        if (take_step)
        begin
            phase_index_next    = step_phase;
            coil_out_next       = step_coil;
            delay_left_next     = step_delay_reg;
            prescale_count_next = '0;
        end
        stepped = take_step;
    end

    // State registers update once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_index_reg    <= '0;
            steps_left_reg     <= '0;
            moving_back_reg    <= 1'b0;
            half_mode_reg      <= 1'b0;
            delay_left_reg     <= '0;
            prescale_count_reg <= '0;
            busy_flag_reg      <= 1'b0;
            coil_out_reg       <= '0;
        end
        else if (in_accept)
        begin
            phase_index_reg    <= phase_index_next;
            steps_left_reg     <= steps_left_next;
            moving_back_reg    <= moving_back_next;
            half_mode_reg      <= half_mode_next;
            delay_left_reg     <= delay_left_next;
            prescale_count_reg <= prescale_count_next;
            busy_flag_reg      <= busy_flag_next;
            coil_out_reg       <= coil_out_next;
        end
    end

    // Result word for this item.
    always_comb
    begin
        result.coil_pattern     = coil_out_next;
        result.busy_res         = busy_flag_next;
        result.step_taken       = stepped;
        result.command_rejected = rejected;
    end

    sps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_word (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    assign coil_pattern     = out_word.coil_pattern;
    assign busy_res         = out_word.busy_res;
    assign step_taken       = out_word.step_taken;
    assign command_rejected = out_word.command_rejected;

endmodule
